// ===== src/pst_pkg.sv =====
// Package for the prime sieve table unit: sizes, item payloads and the
// command/status structs between controller and datapath. No dependencies.
package pst_pkg;

    // Sizing
    localparam int MAX_LIMIT   = 1024;
    localparam int TABLE_DEPTH = 256;

    localparam int LIM_W  = $clog2(MAX_LIMIT + 1);    // holds 0..MAX_LIMIT
    localparam int BIT_AW = $clog2(MAX_LIMIT);        // bitmap address
    localparam int TAB_AW = $clog2(TABLE_DEPTH);      // prime table address
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);  // holds 0..TABLE_DEPTH

    // Fixed field widths of the item payloads
    localparam int KIND_W   = 1;
    localparam int LIMIT_W  = 11;
    localparam int INDEX_W  = 8;
    localparam int VALUE_W  = 10;
    localparam int COUNT_W  = 8;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_SIEVE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_READ  = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [LIMIT_W-1:0] limit;
        logic [INDEX_W-1:0] index;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] prime_value;
        logic               in_range;
        logic [COUNT_W-1:0] prime_count;
        logic [LIMIT_W-1:0] stored_limit;
    } t_out_item;

    typedef struct packed {
        logic load;         // capture input item, clear counters
        logic init_step;    // write one bitmap entry, advance p
        logic p_set2;       // restart p at the first prime
        logic p_inc;        // advance p
        logic strike_start; // m <= p*p
        logic strike_step;  // clear bitmap[m], m <= m + p
        logic col_wr;       // store p if marked, advance p
        logic commit;       // publish the new count
        logic out_load;     // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic kind;
        logic p_lt_lim;
        logic sq_lt_lim;
        logic m_lt_lim;
        logic bit_set;
        logic out_free;
    } t_dp_status;

endpackage

// ===== src/pst_in_if.sv =====
// Input channel of the prime sieve table unit: valid/ready plus request payload.
// Depends on pst_pkg.
interface pst_in_if;
    import pst_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/pst_out_if.sv =====
// Output channel of the prime sieve table unit: valid/ready plus result payload.
// Depends on pst_pkg.
interface pst_out_if;
    import pst_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/prime_sieve_table_unit.sv =====
// Prime sieve table unit, top level: controller, datapath and channel wiring.
// Uses pst_pkg, pst_in_if, pst_out_if, pst_ctrl, pst_datapath.
//
// A sieve request (kind 0) initialises a 1024-entry candidate bitmap up to the
// limit, strikes multiples of each unstruck p with p*p below the limit, and
// collects all primes below the limit into a 256-entry table. Its result
// carries the new count and stored limit. A read request (kind 1) returns the
// stored prime at an index, its in-range flag, the count and the limit.
// One request is in work at a time; the next one is taken while a result
// still waits in the output register. The init pass and the strike loop
// make one bitmap access per cycle; the collect pass visits each candidate
// in a read state and then a write state, as it waits on the registered
// bitmap read.
module prime_sieve_table_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pst_in_if.sink     i_req,
    pst_out_if.source  o_rsp
);
    import pst_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    pst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_read  (i_req.payload.kind == KIND_READ),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pst_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_req.payload),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_out_item  (o_rsp.payload)
    );

    assign i_req.ready = w_in_ready;
endmodule

// ===== src/pst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/pst_datapath.sv =====
// Datapath of the prime sieve table unit: counters, candidate bitmap RAM,
// prime table RAM, stored count/limit and the output register. Uses pst_pkg, pst_ram.
module pst_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pst_pkg::t_in_item     i_in_item,
    input  pst_pkg::t_dp_cmd      i_cmd,
    output pst_pkg::t_dp_status   o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output pst_pkg::t_out_item    o_out_item
);
    import pst_pkg::*;

    logic [KIND_W-1:0]  r_kind;
    logic [LIM_W-1:0]   r_lim;
    logic [INDEX_W-1:0] r_idx;
    logic [LIM_W-1:0]   r_p;
    logic [LIM_W:0]     r_m;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_count;
    logic [LIM_W-1:0]   r_last_limit;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic [LIM_W-1:0]   w_lim_sat;
    logic [2*LIM_W-1:0] w_sq;
    logic               w_bit;
    logic               w_bit_we;
    logic [BIT_AW-1:0]  w_bit_waddr;
    logic               w_bit_wdata;
    logic               w_full;
    logic               w_tab_we;
    logic [BIT_AW-1:0]  w_tab_rdata;
    logic               w_in_range;

    // Limits above the bitmap size saturate
    assign w_lim_sat = (32'(i_in_item.limit) > MAX_LIMIT) ? LIM_W'(MAX_LIMIT)
                                                           : LIM_W'(i_in_item.limit);

    assign w_sq = (2*LIM_W)'(r_p) * (2*LIM_W)'(r_p);

    assign w_bit_we    = i_cmd.init_step | i_cmd.strike_step;
    assign w_bit_waddr = i_cmd.init_step ? r_p[BIT_AW-1:0] : r_m[BIT_AW-1:0];
    assign w_bit_wdata = i_cmd.init_step & (r_p >= LIM_W'(2));

    pst_ram #(
        .WIDTH (1),
        .DEPTH (MAX_LIMIT)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_bit_we),
        .i_waddr (w_bit_waddr),
        .i_wdata (w_bit_wdata),
        .i_raddr (r_p[BIT_AW-1:0]),
        .o_rdata (w_bit)
    );

    assign w_full   = (r_cnt >= CNT_W'(TABLE_DEPTH));
    assign w_tab_we = i_cmd.col_wr & w_bit & ~w_full;

    pst_ram #(
        .WIDTH (BIT_AW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_waddr (r_cnt[TAB_AW-1:0]),
        .i_wdata (r_p[BIT_AW-1:0]),
        .i_raddr (TAB_AW'(r_idx)),
        .o_rdata (w_tab_rdata)
    );

    assign w_in_range = (r_kind == KIND_READ) &&
                        (32'(r_idx) < 32'(r_count)) &&
                        (32'(r_idx) < TABLE_DEPTH);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_last_limit <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load && i_in_item.kind == KIND_SIEVE) begin
                r_last_limit <= w_lim_sat;
            end
            if (i_cmd.commit) begin
                r_count <= r_cnt;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_in_item.kind;
            r_lim  <= w_lim_sat;
            r_idx  <= i_in_item.index;
            r_cnt  <= '0;
        end else if (w_tab_we) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end

        if (i_cmd.load) begin
            r_p <= '0;
        end else if (i_cmd.p_set2) begin
            r_p <= LIM_W'(2);
        end else if (i_cmd.init_step || i_cmd.p_inc || i_cmd.col_wr) begin
            r_p <= r_p + LIM_W'(1);
        end

        if (i_cmd.strike_start) begin
            r_m <= (LIM_W+1)'(w_sq);
        end else if (i_cmd.strike_step) begin
            r_m <= r_m + (LIM_W+1)'(r_p);
        end

        if (i_cmd.out_load) begin
            r_out_item.prime_value  <= w_in_range ? VALUE_W'(w_tab_rdata) : '0;
            r_out_item.in_range     <= w_in_range;
            r_out_item.prime_count  <= COUNT_W'(r_count);
            r_out_item.stored_limit <= LIMIT_W'(r_last_limit);
        end
    end

    assign o_status.kind      = (r_kind == KIND_READ);
    assign o_status.p_lt_lim  = (r_p < r_lim);
    assign o_status.sq_lt_lim = (w_sq < (2*LIM_W)'(r_lim));
    assign o_status.m_lt_lim  = (r_m < (LIM_W+1)'(r_lim));
    assign o_status.bit_set   = w_bit;
    assign o_status.out_free  = ~r_out_valid | i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
endmodule

// ===== src/pst_ctrl.sv =====
// Controller of the prime sieve table unit: one-hot state machine that
// sequences init, strike, collect and read phases. Uses pst_pkg.
module pst_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_read,
    output logic                 o_in_ready,
    input  pst_pkg::t_dp_status  i_status,
    output pst_pkg::t_dp_cmd     o_cmd
);
    import pst_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_INIT    = 9'b000000010,
        S_STR_CHK = 9'b000000100,
        S_STR_TST = 9'b000001000,
        S_STRIKE  = 9'b000010000,
        S_COL_RD  = 9'b000100000,
        S_COL_WR  = 9'b001000000,
        S_RD      = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_in_read ? S_RD : S_INIT;
                end
            end
            S_INIT: begin
                if (i_status.p_lt_lim) begin
                    o_cmd.init_step = 1'b1;
                end else begin
                    o_cmd.p_set2 = 1'b1;
                    n_state      = S_STR_CHK;
                end
            end
            S_STR_CHK: begin
                // bitmap read of p is issued here, data arrives next cycle
                if (i_status.sq_lt_lim) begin
                    n_state = S_STR_TST;
                end else begin
                    o_cmd.p_set2 = 1'b1;
                    n_state      = S_COL_RD;
                end
            end
            S_STR_TST: begin
                if (i_status.bit_set) begin
                    o_cmd.strike_start = 1'b1;
                    n_state            = S_STRIKE;
                end else begin
                    o_cmd.p_inc = 1'b1;
                    n_state     = S_STR_CHK;
                end
            end
            S_STRIKE: begin
                if (i_status.m_lt_lim) begin
                    o_cmd.strike_step = 1'b1;
                end else begin
                    o_cmd.p_inc = 1'b1;
                    n_state     = S_STR_CHK;
                end
            end
            S_COL_RD: begin
                if (i_status.p_lt_lim) begin
                    n_state = S_COL_WR;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_COL_WR: begin
                o_cmd.col_wr = 1'b1;
                n_state      = S_COL_RD;
            end
            S_RD: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
